/* design/srt_pkg.sv */
// shared constants for the sorted record table: request and status codes, defaults
package srt_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_ROOM_CHARS = 8;

	localparam int REQ_W      = 2;
	localparam int ID_W       = 16;
	localparam int ROOM_KEY_W = 64;
	localparam int DEV_W      = 2;
	localparam int VALUE_W    = 32;
	localparam int TIME_W     = 20;
	localparam int STATUS_W   = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

endpackage

/* design/sorted_record_table_core.sv */
// sorted record table: ordered record store with insert, delete by id and indexed read
//
// Usage: a request beat is taken at a rising edge with start high and busy low;
// req_type selects insert, delete by id or read at read_index. Each request
// returns exactly one result beat, marked by done for one cycle, carrying status,
// entry_count and, for a successful read, the fields of the entry read (else zero).
// The receiver cannot stall; busy stays high until the result beat is shown and
// the next request can be taken in the cycle done is high.
// Records sit in a table memory with one write port and one registered read port,
// walked by one shared compare unit. Each scanned or shifted entry takes a read
// state, then a compare or write state. A read request reads the entry and shows
// it; an insert scans for its place, shifts the later entries toward the tail,
// then writes the new entry; a delete scans for the id, then shifts the later
// entries up over it. A full-table insert, empty-table delete, out-of-range read
// or unused request is answered straight from idle.
// Reset clears the entry count and the control registers, not the table memory;
// it needs no clearing pass, since entries at or beyond the count are never read.
module sorted_record_table_core
	import srt_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int ROOM_CHARS = DEF_ROOM_CHARS,
	localparam int IDX_W     = $clog2(CAPACITY),
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [ID_W-1:0]       rec_id,
	input  logic [ROOM_KEY_W-1:0] room_key,
	input  logic [DEV_W-1:0]      device_code,
	input  logic [VALUE_W-1:0]    value_bits,
	input  logic [TIME_W-1:0]     time_sec,
	input  logic [IDX_W-1:0]      read_index,
	output logic                  done,
	output logic [STATUS_W-1:0]   status,
	output logic [CNT_W-1:0]      entry_count,
	output logic [ID_W-1:0]       out_id,
	output logic [ROOM_KEY_W-1:0] out_room,
	output logic [DEV_W-1:0]      out_device,
	output logic [VALUE_W-1:0]    out_value,
	output logic [TIME_W-1:0]     out_time
);

	localparam int ROOM_W   = 8 * ROOM_CHARS;
	localparam int ROOM_PAD = ROOM_KEY_W - ROOM_W;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [ROOM_W-1:0]  room;
		logic [DEV_W-1:0]   dev;
		logic [VALUE_W-1:0] value;
		logic [TIME_W-1:0]  tstamp;
	} rec_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND_RD,
		S_FIND_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_WRITE,
		S_READ
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    ptr_q;
	logic [IDX_W-1:0]    pos_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	rec_t                out_rec_q;

	req_t                req_q;
	rec_t                new_q;

	rec_t                mem [CAPACITY];
	rec_t                rdata_q;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	rec_t                mem_wdata;
	logic [IDX_W-1:0]    rd_addr;

	logic                accept;
	logic [CNT_W-1:0]    ptr_next;
	logic                ins_hit;
	logic                del_hit;

	assign accept   = start && (state_q == S_IDLE);
	assign ptr_next = CNT_W'(ptr_q) + CNT_W'(1);

	// shared compare unit: insert position and id match against the entry read
	assign ins_hit = (new_q.room > rdata_q.room) ||
		((new_q.room == rdata_q.room) && (new_q.tstamp <= rdata_q.tstamp));
	assign del_hit = (new_q.id == rdata_q.id);

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q         <= req_t'(req_type);
			new_q.id      <= rec_id;
			new_q.room    <= room_key[ROOM_KEY_W-1 -: ROOM_W];
			new_q.dev     <= device_code;
			new_q.value   <= value_bits;
			new_q.tstamp  <= time_sec;
		end
	end

	// memory port controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = rdata_q;
		rd_addr   = ptr_q;
		case (state_q)
			S_IDLE: begin
				rd_addr = read_index;
			end
			S_SHIFT_RD: begin
				if (req_q == REQ_INSERT) begin
					rd_addr = ptr_q - IDX_W'(1);
				end else begin
					rd_addr = ptr_q + IDX_W'(1);
				end
			end
			S_SHIFT_WR: begin
				mem_we = 1'b1;
			end
			S_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = new_q;
			end
			default: begin
				rd_addr = ptr_q;
			end
		endcase
	end

	// table memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			pos_q     <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			out_rec_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_rec_q <= '0;
						status_q  <= ST_OK;
						ptr_q     <= '0;
						pos_q     <= '0;
						case (req_type)
							REQ_INSERT: begin
								if (count_q == CNT_W'(CAPACITY)) begin
									status_q <= ST_FULL;
									done_q   <= 1'b1;
								end else if (count_q == '0) begin
									state_q <= S_WRITE;
								end else begin
									state_q <= S_FIND_RD;
								end
							end
							REQ_DELETE: begin
								if (count_q == '0) begin
									status_q <= ST_NOT_FOUND;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_FIND_RD;
								end
							end
							REQ_READ: begin
								if (CNT_W'(read_index) >= count_q) begin
									status_q <= ST_RANGE;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					out_rec_q <= rdata_q;
					done_q    <= 1'b1;
					state_q   <= S_IDLE;
				end
				S_FIND_RD: begin
					state_q <= S_FIND_CMP;
				end
				S_FIND_CMP: begin
					if (req_q == REQ_INSERT) begin
						if (ins_hit) begin
							// open a gap at this entry: shift from the tail down
							pos_q   <= ptr_q;
							ptr_q   <= IDX_W'(count_q);
							state_q <= S_SHIFT_RD;
						end else if (ptr_next == count_q) begin
							pos_q   <= IDX_W'(count_q);
							state_q <= S_WRITE;
						end else begin
							ptr_q   <= IDX_W'(ptr_next);
							state_q <= S_FIND_RD;
						end
					end else begin
						if (del_hit) begin
							if (ptr_next == count_q) begin
								count_q <= count_q - CNT_W'(1);
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_SHIFT_RD;
							end
						end else if (ptr_next == count_q) begin
							status_q <= ST_NOT_FOUND;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							ptr_q   <= IDX_W'(ptr_next);
							state_q <= S_FIND_RD;
						end
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					if (req_q == REQ_INSERT) begin
						if (ptr_q - IDX_W'(1) == pos_q) begin
							state_q <= S_WRITE;
						end else begin
							ptr_q   <= ptr_q - IDX_W'(1);
							state_q <= S_SHIFT_RD;
						end
					end else begin
						// delete closes the gap up to the last held entry
						if (ptr_next + CNT_W'(1) == count_q) begin
							count_q <= count_q - CNT_W'(1);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							ptr_q   <= IDX_W'(ptr_next);
							state_q <= S_SHIFT_RD;
						end
					end
				end
				S_WRITE: begin
					count_q <= count_q + CNT_W'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result beat
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = count_q;
	assign out_id      = out_rec_q.id;
	assign out_room    = ROOM_KEY_W'(out_rec_q.room) << ROOM_PAD;
	assign out_device  = out_rec_q.dev;
	assign out_value   = out_rec_q.value;
	assign out_time    = out_rec_q.tstamp;

endmodule
